@@ rtl/core/sssd_pkg.sv @@
// Shared types and constants for the sample-set standard deviation block.
// Used by the controller, the datapath, the square root unit and the top level.
// No dependencies.
package sssd_pkg;

    // Default depth of the sample store
    localparam int MAX_SAMPLES_DEF = 1024;

    // Fixed field widths
    localparam int SAMPLE_W = 32;
    localparam int RES_W    = 40;
    localparam int FRAC_W   = 8;
    // Variance is scaled by 2^16 so that its root carries 8 fraction bits
    localparam int VAR_SH   = 16;
    // Scaled variance always fits in 80 bits, its root in 40
    localparam int T_W      = 2 * RES_W;

    // Partial product selected in the squaring steps
    typedef enum logic [1:0] {
        SQ_LO,
        SQ_MID,
        SQ_HI
    } t_sq_step;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic     take;        // store and sum the accepted sample
        logic     n_sq;        // square the count
        logic     n_cube;      // cube the count
        logic     div_mean;    // start divide for the mean
        logic     div_var;     // start divide for the variance
        logic     mean_cap;    // capture the mean quotient
        logic     rd;          // read the store at the pass index
        logic     mul;         // n * x
        logic     dif;         // |n*x - sum|
        logic     sq_en;       // accumulate one partial square
        t_sq_step sq_step;
        logic     idx_next;    // advance the pass index
        logic     sqrt_start;  // start the root on the divider quotient
        logic     out_load;    // load the result register
        logic     clr;         // clear the set for the next one
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic div_done;
        logic sqrt_done;
        logic idx_last;
    } t_sts;

endpackage

@@ rtl/core/sssd_div.sv @@
// Restoring serial divider, one quotient bit per cycle.
// Depends on nothing; widths come from the instantiating datapath.
module sssd_div #(
    parameter int DVD_W = 113,
    parameter int DVS_W = 33
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0]   rem_sh;
    logic             ge;
    logic [DVS_W-1:0] n_rem;
    logic [DVD_W-1:0] n_quo;

    // One shift and trial subtract
    always_comb begin
        rem_sh = {r_rem, r_quo[DVD_W-1]};
        ge     = rem_sh >= {1'b0, r_dvs};
        n_rem  = ge ? DVS_W'(rem_sh - {1'b0, r_dvs}) : DVS_W'(rem_sh);
        n_quo  = {r_quo[DVD_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_quo <= n_quo;
                r_rem <= n_rem;
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

@@ rtl/core/sssd_sqrt.sv @@
// Digit-by-digit integer square root, one result bit per cycle.
// Depends on sssd_pkg for the operand and result widths.
module sssd_sqrt
    import sssd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [T_W-1:0]   i_value,
    output logic             o_done,
    output logic [RES_W-1:0] o_root
);

    localparam int CNT_W = $clog2(RES_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [T_W-1:0]   r_t;
    logic [RES_W:0]   r_rem;
    logic [RES_W-1:0] r_root;

    logic [RES_W+2:0] rem_sh;
    logic [RES_W+2:0] trial;
    logic             ge;

    // Bring down two bits and try the next root bit
    always_comb begin
        rem_sh = {r_rem, r_t[T_W-1 -: 2]};
        trial  = {1'b0, r_root, 2'b01};
        ge     = rem_sh >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(RES_W);
                r_t    <= i_value;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_t    <= {r_t[T_W-3:0], 2'b00};
                r_rem  <= ge ? (RES_W+1)'(rem_sh - trial) : (RES_W+1)'(rem_sh);
                r_root <= {r_root[RES_W-2:0], ge};
                r_cnt  <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

@@ rtl/core/sssd_dp.sv @@
// Datapath: sample store, running sum, deviation square accumulator,
// shared divider and square root unit. Depends on sssd_pkg, sssd_div, sssd_sqrt.
module sssd_dp
    import sssd_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    parameter int CW          = $clog2(MAX_SAMPLES + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic [SAMPLE_W-1:0] i_sample,
    output t_sts                o_sts,
    output logic [RES_W-1:0]    o_mean_value,
    output logic [RES_W-1:0]    o_std_deviation,
    output logic [CW-1:0]       o_sample_count,
    output logic                o_overflow
);

    localparam int ADDR_W = $clog2(MAX_SAMPLES);
    localparam int DW     = SAMPLE_W + CW;      // n*x and the sum
    localparam int H      = (DW + 1) / 2;       // split for squaring
    localparam int AW     = 2 * DW + CW;        // sum of squared deviations
    localparam int DVD_W  = AW + VAR_SH;
    localparam int N2_W   = 2 * CW;
    localparam int DVS_W  = 3 * CW;

    logic [SAMPLE_W-1:0] mem [MAX_SAMPLES];

    logic [CW-1:0]       r_count;
    logic [DW-1:0]       r_sum;
    logic                r_drop;
    logic [N2_W-1:0]     r_n2;
    logic [DVS_W-1:0]    r_n3;
    logic [RES_W-1:0]    r_mean;
    logic [ADDR_W-1:0]   r_idx;
    logic [SAMPLE_W-1:0] r_rdata;
    logic [DW-1:0]       r_nx;
    logic [DW-1:0]       r_d;
    logic [AW-1:0]       r_acc;
    logic [RES_W-1:0]    r_out_mean;
    logic [RES_W-1:0]    r_out_std;
    logic [CW-1:0]       r_out_cnt;
    logic                r_out_ovf;

    logic                room;
    logic [H-1:0]        op_a;
    logic [H-1:0]        op_b;
    logic [2*H-1:0]      prod;
    logic [AW-1:0]       term;
    logic                div_start;
    logic [DVD_W-1:0]    dvd;
    logic [DVS_W-1:0]    dvs;
    logic                div_done;
    logic [DVD_W-1:0]    quo;
    logic                sqrt_done;
    logic [RES_W-1:0]    root;

    assign room = r_count < CW'(MAX_SAMPLES);

    // Store write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && room) begin
            mem[r_count[ADDR_W-1:0]] <= i_sample;
        end
        if (i_cmd.rd) begin
            r_rdata <= mem[r_idx];
        end
    end

    // Shared multiplier for the partial squares of the deviation
    always_comb begin
        case (i_cmd.sq_step)
            SQ_LO: begin
                op_a = r_d[H-1:0];
                op_b = r_d[H-1:0];
            end
            SQ_MID: begin
                op_a = H'(r_d[DW-1:H]);
                op_b = r_d[H-1:0];
            end
            SQ_HI: begin
                op_a = H'(r_d[DW-1:H]);
                op_b = H'(r_d[DW-1:H]);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
        prod = (2*H)'(op_a) * (2*H)'(op_b);
        case (i_cmd.sq_step)
            SQ_LO:   term = AW'(prod);
            SQ_MID:  term = AW'(prod) << (H + 1);
            SQ_HI:   term = AW'(prod) << (2 * H);
            default: term = '0;
        endcase
    end

    // Set accumulation, pass arithmetic and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
            r_drop  <= 1'b0;
            r_idx   <= '0;
            r_acc   <= '0;
        end else begin
            if (i_cmd.clr) begin
                r_count <= '0;
                r_sum   <= '0;
                r_drop  <= 1'b0;
                r_idx   <= '0;
                r_acc   <= '0;
            end else begin
                if (i_cmd.take) begin
                    if (room) begin
                        r_count <= r_count + CW'(1);
                        r_sum   <= r_sum + DW'(i_sample);
                    end else begin
                        r_drop <= 1'b1;
                    end
                end
                if (i_cmd.idx_next) begin
                    r_idx <= r_idx + ADDR_W'(1);
                end
                if (i_cmd.sq_en) begin
                    r_acc <= r_acc + term;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.n_sq) begin
            r_n2 <= N2_W'(r_count) * N2_W'(r_count);
        end
        if (i_cmd.n_cube) begin
            r_n3 <= DVS_W'(r_n2) * DVS_W'(r_count);
        end
        if (i_cmd.mean_cap) begin
            r_mean <= quo[RES_W-1:0];
        end
        if (i_cmd.mul) begin
            r_nx <= DW'(r_count) * DW'(r_rdata);
        end
        if (i_cmd.dif) begin
            r_d <= (r_nx >= r_sum) ? (r_nx - r_sum) : (r_sum - r_nx);
        end
        if (i_cmd.out_load) begin
            r_out_mean <= r_mean;
            r_out_std  <= root;
            r_out_cnt  <= r_count;
            r_out_ovf  <= r_drop;
        end
    end

    // Divider operands: mean first, then the scaled variance
    assign div_start = i_cmd.div_mean | i_cmd.div_var;
    assign dvd = i_cmd.div_var ? {r_acc, VAR_SH'(0)} : DVD_W'({r_sum, FRAC_W'(0)});
    assign dvs = i_cmd.div_var ? r_n3 : DVS_W'(r_count);

    sssd_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dvd),
        .i_divisor  (dvs),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    sssd_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_start),
        .i_value (quo[T_W-1:0]),
        .o_done  (sqrt_done),
        .o_root  (root)
    );

    assign o_sts.div_done  = div_done;
    assign o_sts.sqrt_done = sqrt_done;
    assign o_sts.idx_last  = (CW'(r_idx) + CW'(1)) == r_count;

    assign o_mean_value    = r_out_mean;
    assign o_std_deviation = r_out_std;
    assign o_sample_count  = r_out_cnt;
    assign o_overflow      = r_out_ovf;

endmodule

@@ rtl/core/sssd_ctrl.sv @@
// Controller: sequences loading, the mean divide, the deviation pass,
// the variance divide and the root. Depends on sssd_pkg.
module sssd_ctrl
    import sssd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_last_sample,
    input  logic i_out_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_in_stall,
    output logic o_out_valid
);

    typedef enum logic [3:0] {
        S_LOAD,
        S_SQ_N,
        S_CUBE,
        S_MEAN,
        S_RD,
        S_MUL,
        S_DIF,
        S_SQ0,
        S_SQ1,
        S_SQ2,
        S_VAR,
        S_VWAIT,
        S_SQRT,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    // Commands and next state
    always_comb begin
        o_cmd         = '0;
        o_cmd.sq_step = SQ_LO;
        n_state       = r_state;
        case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    if (i_last_sample) begin
                        n_state = S_SQ_N;
                    end
                end
            end
            S_SQ_N: begin
                o_cmd.n_sq = 1'b1;
                n_state    = S_CUBE;
            end
            S_CUBE: begin
                o_cmd.n_cube   = 1'b1;
                o_cmd.div_mean = 1'b1;
                n_state        = S_MEAN;
            end
            S_MEAN: begin
                if (i_sts.div_done) begin
                    o_cmd.mean_cap = 1'b1;
                    n_state        = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIF;
            end
            S_DIF: begin
                o_cmd.dif = 1'b1;
                n_state   = S_SQ0;
            end
            S_SQ0: begin
                o_cmd.sq_en   = 1'b1;
                o_cmd.sq_step = SQ_LO;
                n_state       = S_SQ1;
            end
            S_SQ1: begin
                o_cmd.sq_en   = 1'b1;
                o_cmd.sq_step = SQ_MID;
                n_state       = S_SQ2;
            end
            S_SQ2: begin
                o_cmd.sq_en    = 1'b1;
                o_cmd.sq_step  = SQ_HI;
                o_cmd.idx_next = 1'b1;
                n_state        = i_sts.idx_last ? S_VAR : S_RD;
            end
            S_VAR: begin
                o_cmd.div_var = 1'b1;
                n_state       = S_VWAIT;
            end
            S_VWAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.sqrt_start = 1'b1;
                    n_state          = S_SQRT;
                end
            end
            S_SQRT: begin
                if (i_sts.sqrt_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.clr      = 1'b1;
                    n_state        = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // State and result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = r_state != S_LOAD;
    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/core/sample_set_std_deviation.sv @@
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_stall    i_sample, i_last_sample
// result    out        o_out_valid / i_out_stall  o_mean_value, o_std_deviation,
//                                                  o_sample_count, o_overflow
//
// Samples are taken one per cycle while o_in_stall is low. After the last one
// the input stalls for two serial divides of 3*CW+80 bits (CW count bits), a
// deviation pass that reads, multiplies, differences and squares each stored
// sample, and a 40-step square root. A waiting result holds in the output
// register while the next set loads; the next result enters it only once it
// is free, with the input stalled until then. Reset is synchronous, active low,
// and needs no clearing pass. Top level; depends on sssd_pkg, sssd_ctrl and sssd_dp.
module sample_set_std_deviation
    import sssd_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    parameter int CW          = $clog2(MAX_SAMPLES + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic                i_last_sample,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [RES_W-1:0]    o_mean_value,
    output logic [RES_W-1:0]    o_std_deviation,
    output logic [CW-1:0]       o_sample_count,
    output logic                o_overflow
);

    t_cmd cmd;
    t_sts sts;

    sssd_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_last_sample (i_last_sample),
        .i_out_stall   (i_out_stall),
        .i_sts         (sts),
        .o_cmd         (cmd),
        .o_in_stall    (o_in_stall),
        .o_out_valid   (o_out_valid)
    );

    sssd_dp #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .CW          (CW)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_sample        (i_sample),
        .o_sts           (sts),
        .o_mean_value    (o_mean_value),
        .o_std_deviation (o_std_deviation),
        .o_sample_count  (o_sample_count),
        .o_overflow      (o_overflow)
    );

endmodule
